[hw/rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, codes and types of the k-way merge heap engine.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // sizes
  localparam int MAX_LISTS = 16;
  localparam int IDX_W     = $clog2(MAX_LISTS);
  localparam int CNT_W     = $clog2(MAX_LISTS + 1);
  localparam int VAL_W     = 32;
  localparam int SRC_W     = 4;

  // operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_BUILD   = 2'd2;
  localparam logic [1:0] OP_ADVANCE = 2'd3;

  // result status codes
  localparam logic [1:0] RS_OK    = 2'd0;
  localparam logic [1:0] RS_FULL  = 2'd1;
  localparam logic [1:0] RS_EMPTY = 2'd2;

  // one heap entry
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [SRC_W-1:0]        src;
  } kwm_entry_t;

  localparam int ENTRY_W = $bits(kwm_entry_t);

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_CAP,
    S_LAST_CAP,
    S_SIFT_LEFT,
    S_SIFT_RIGHT,
    S_SIFT_PICK,
    S_SIFT_END,
    S_REPORT
  } kwm_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic load;
    logic load_err;
    logic adv_err;
    logic adv_next;
    logic adv_last;
    logic build_init;
    logic build_rd;
    logic build_cap;
    logic last_cap;
    logic sift_left;
    logic sift_right;
    logic sift_pick;
    logic sift_fin;
    logic build_dec;
    logic report;
  } kwm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic multi;
    logic left_ok;
    logic moving;
    logic build_more;
  } kwm_stat_t;

endpackage

[hw/rtl/kway_merge_min_heap.sv]
// ----------------------------------------------------------------------------
// kway_merge_min_heap
// K-way merge engine on a binary min-heap of (value, source list) entries.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with out_valid high, and must be taken
// then since the block cannot be held off. Clear, load, any error and an
// advance that empties the heap go straight to the result. An advance with
// a sift walks down the heap level by level; build sifts each internal node
// in turn, from the last one back to the root. The heap memory has a single
// read port, so each level of the sift reads the left child and then the
// right child. busy drops in the cycle the result is shown, so the next
// operation may start alongside it.
module kway_merge_min_heap
  import kwm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic [SRC_W-1:0]        in_entry_source,
  input  logic                    in_has_next,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_popped_value,
  output logic [SRC_W-1:0]        out_popped_source,
  output logic [SRC_W-1:0]        out_top_source,
  output logic [CNT_W-1:0]        out_remaining
);

  kwm_cmd_t  cmd;
  kwm_stat_t stat;

  // sequencer
  kwm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_has_next  (in_has_next),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // heap datapath
  kwm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_entry_value    (in_entry_value),
    .in_entry_source   (in_entry_source),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_popped_value  (out_popped_value),
    .out_popped_source (out_popped_source),
    .out_top_source    (out_top_source),
    .out_remaining     (out_remaining)
  );

endmodule

[hw/rtl/kwm_ram.sv]
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/kwm_datapath.sv]
// ----------------------------------------------------------------------------
// kwm_datapath
// Heap store, entry count, sift registers and result registers.
// ----------------------------------------------------------------------------
module kwm_datapath
  import kwm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  kwm_cmd_t                cmd,
  output kwm_stat_t               stat,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic [SRC_W-1:0]        in_entry_source,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_popped_value,
  output logic [SRC_W-1:0]        out_popped_source,
  output logic [SRC_W-1:0]        out_top_source,
  output logic [CNT_W-1:0]        out_remaining
);

  // control registers
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    valid_r, valid_nxt;

  // payload registers
  kwm_entry_t              top_r, top_nxt;
  kwm_entry_t              cur_r, cur_nxt;
  kwm_entry_t              lft_r, lft_nxt;
  logic                    lsel_r, lsel_nxt;
  logic [IDX_W-1:0]        node_r, node_nxt;
  logic [IDX_W-1:0]        bidx_r, bidx_nxt;
  logic [1:0]              st_r, st_nxt;
  kwm_entry_t              pop_r, pop_nxt;
  logic [1:0]              ost_r, ost_nxt;
  kwm_entry_t              opop_r, opop_nxt;
  logic [SRC_W-1:0]        otop_r, otop_nxt;
  logic [CNT_W-1:0]        orem_r, orem_nxt;

  // memory port signals
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  kwm_entry_t              wr_data;
  logic [IDX_W-1:0]        rd_addr;
  logic [ENTRY_W-1:0]      rd_raw;
  kwm_entry_t              rd_ent;

  // child indexes of the current node
  logic [CNT_W-1:0]        left_idx;
  logic [CNT_W-1:0]        right_idx;
  logic                    left_ok;
  logic                    right_ok;
  logic signed [VAL_W-1:0] best_val;
  logic                    take_r;

  assign rd_ent    = kwm_entry_t'(rd_raw);
  assign left_idx  = {node_r, 1'b1};
  assign right_idx = {node_r, 1'b0} + CNT_W'(2);
  assign left_ok   = left_idx < count_r;
  assign right_ok  = left_ok && (right_idx < count_r);

  // choice among node, left and right child
  assign best_val = lsel_r ? lft_r.val : cur_r.val;
  assign take_r   = right_ok && ($signed(rd_ent.val) < $signed(best_val));

  // heap store
  kwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LISTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_data)),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_r;
    wr_data = cur_r;
    if (cmd.load) begin
      wr_en   = 1'b1;
      wr_addr = count_r[IDX_W-1:0];
      wr_data = '{val: in_entry_value, src: in_entry_source};
    end else if (cmd.sift_fin) begin
      wr_en   = 1'b1;
    end else if (cmd.sift_pick) begin
      wr_en   = 1'b1;
      if (take_r) begin
        wr_data = rd_ent;
      end else if (lsel_r) begin
        wr_data = lft_r;
      end
    end
  end

  // read address selection
  always_comb begin
    rd_addr = node_r;
    if (cmd.adv_last) begin
      rd_addr = IDX_W'(count_r - CNT_W'(1));
    end else if (cmd.build_rd) begin
      rd_addr = bidx_r;
    end else if (cmd.sift_left) begin
      rd_addr = left_idx[IDX_W-1:0];
    end else if (cmd.sift_right) begin
      rd_addr = right_idx[IDX_W-1:0];
    end
  end

  // next state of all datapath registers
  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    cur_nxt   = cur_r;
    lft_nxt   = lft_r;
    lsel_nxt  = lsel_r;
    node_nxt  = node_r;
    bidx_nxt  = bidx_r;
    st_nxt    = st_r;
    pop_nxt   = pop_r;
    valid_nxt = 1'b0;
    ost_nxt   = ost_r;
    opop_nxt  = opop_r;
    otop_nxt  = otop_r;
    orem_nxt  = orem_r;

    // staging of the result fields
    if (cmd.accept) begin
      st_nxt  = RS_OK;
      pop_nxt = '0;
    end
    if (cmd.load_err) begin
      st_nxt = RS_FULL;
    end
    if (cmd.adv_err) begin
      st_nxt = RS_EMPTY;
    end

    // count updates
    if (cmd.clear) begin
      count_nxt = '0;
    end
    if (cmd.load) begin
      count_nxt = count_r + CNT_W'(1);
    end

    // pop with refill or with last entry
    if (cmd.adv_next) begin
      pop_nxt  = top_r;
      cur_nxt  = '{val: in_entry_value, src: top_r.src};
      node_nxt = '0;
    end
    if (cmd.adv_last) begin
      pop_nxt   = top_r;
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.last_cap) begin
      cur_nxt  = rd_ent;
      node_nxt = '0;
    end

    // bottom-up build walk
    if (cmd.build_init) begin
      bidx_nxt = IDX_W'((count_r - CNT_W'(2)) >> 1);
    end
    if (cmd.build_rd) begin
      node_nxt = bidx_r;
    end
    if (cmd.build_cap) begin
      cur_nxt = rd_ent;
    end
    if (cmd.build_dec) begin
      bidx_nxt = bidx_r - IDX_W'(1);
    end

    // sift steps
    if (cmd.sift_right) begin
      lft_nxt  = rd_ent;
      lsel_nxt = $signed(rd_ent.val) < $signed(cur_r.val);
    end
    if (cmd.sift_pick) begin
      if (take_r) begin
        node_nxt = right_idx[IDX_W-1:0];
      end else if (lsel_r) begin
        node_nxt = left_idx[IDX_W-1:0];
      end
    end

    // mirror of the top entry
    if (wr_en && (wr_addr == '0)) begin
      top_nxt = wr_data;
    end

    // result registers
    if (cmd.report) begin
      valid_nxt = 1'b1;
      ost_nxt   = st_r;
      opop_nxt  = pop_r;
      otop_nxt  = (count_r == '0) ? '0 : top_r.src;
      orem_nxt  = count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    cur_r  <= cur_nxt;
    lft_r  <= lft_nxt;
    lsel_r <= lsel_nxt;
    node_r <= node_nxt;
    bidx_r <= bidx_nxt;
    st_r   <= st_nxt;
    pop_r  <= pop_nxt;
    ost_r  <= ost_nxt;
    opop_r <= opop_nxt;
    otop_r <= otop_nxt;
    orem_r <= orem_nxt;
  end

  // status to the controller
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r >= CNT_W'(MAX_LISTS));
  assign stat.multi      = (count_r >= CNT_W'(2));
  assign stat.left_ok    = left_ok;
  assign stat.moving     = take_r || lsel_r;
  assign stat.build_more = (bidx_r != '0);

  // result ports
  assign out_valid         = valid_r;
  assign out_status        = ost_r;
  assign out_popped_value  = opop_r.val;
  assign out_popped_source = opop_r.src;
  assign out_top_source    = otop_r;
  assign out_remaining     = orem_r;

endmodule

[hw/rtl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for load, build, advance and the sift-down walk.
// ----------------------------------------------------------------------------
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_operation,
  input  logic       in_has_next,
  input  kwm_stat_t  stat,
  output kwm_cmd_t   cmd,
  output logic       busy
);

  kwm_state_t state_r, state_nxt;
  logic       bld_r, bld_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    bld_nxt   = bld_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          bld_nxt   = 1'b0;
          state_nxt = S_REPORT;
          case (in_operation)
            OP_BUILD: begin
              if (stat.multi) begin
                bld_nxt   = 1'b1;
                state_nxt = S_BUILD_RD;
              end
            end
            OP_ADVANCE: begin
              if (!stat.empty) begin
                if (in_has_next) begin
                  state_nxt = S_SIFT_LEFT;
                end else if (stat.multi) begin
                  state_nxt = S_LAST_CAP;
                end
              end
            end
            default: state_nxt = S_REPORT;
          endcase
        end
      end
      S_BUILD_RD:   state_nxt = S_BUILD_CAP;
      S_BUILD_CAP:  state_nxt = S_SIFT_LEFT;
      S_LAST_CAP:   state_nxt = S_SIFT_LEFT;
      S_SIFT_LEFT:  state_nxt = stat.left_ok ? S_SIFT_RIGHT : S_SIFT_END;
      S_SIFT_RIGHT: state_nxt = S_SIFT_PICK;
      S_SIFT_PICK:  state_nxt = stat.moving ? S_SIFT_LEFT : S_SIFT_END;
      S_SIFT_END: begin
        state_nxt = (bld_r && stat.build_more) ? S_BUILD_RD : S_REPORT;
      end
      S_REPORT:     state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_operation)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOAD: begin
              cmd.load     = !stat.full;
              cmd.load_err = stat.full;
            end
            OP_BUILD: cmd.build_init = stat.multi;
            OP_ADVANCE: begin
              cmd.adv_err  = stat.empty;
              cmd.adv_next = !stat.empty && in_has_next;
              cmd.adv_last = !stat.empty && !in_has_next;
            end
            default: cmd.accept = 1'b1;
          endcase
        end
      end
      S_BUILD_RD:   cmd.build_rd = 1'b1;
      S_BUILD_CAP:  cmd.build_cap = 1'b1;
      S_LAST_CAP:   cmd.last_cap = 1'b1;
      S_SIFT_LEFT: begin
        cmd.sift_left = stat.left_ok;
        cmd.sift_fin  = !stat.left_ok;
      end
      S_SIFT_RIGHT: cmd.sift_right = 1'b1;
      S_SIFT_PICK:  cmd.sift_pick = 1'b1;
      S_SIFT_END:   cmd.build_dec = bld_r && stat.build_more;
      S_REPORT:     cmd.report = 1'b1;
      default:      cmd = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bld_r   <= bld_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hw/rtl/kwm_checker.sv]
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the k-way merge engine, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker
  import kwm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [1:0]              out_status,
  input logic signed [VAL_W-1:0] out_popped_value,
  input logic [SRC_W-1:0]        out_popped_source,
  input logic [SRC_W-1:0]        out_top_source,
  input logic [CNT_W-1:0]        out_remaining
);

  // an accepted operation keeps the block busy until its result
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after transfer in");

  // a result only closes a busy stretch
  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result without work in progress");

  // one strobe per result
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // failed operations pop nothing
  a_error_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != RS_OK) |->
      (out_popped_value == '0) && (out_popped_source == '0))
    else $error("error result carries a popped entry");

  // empty heap has no top and count stays in range
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_remaining <= CNT_W'(MAX_LISTS)) &&
      ((out_remaining != '0) || (out_top_source == '0)))
    else $error("remaining count or top source out of range");

endmodule

bind kway_merge_min_heap kwm_checker u_kwm_checker (.*);
